/* design/lnc_pkg.sv */
package lnc_pkg;

  // fixed widths of the item fields
  localparam int PitchCount  = 128;
  localparam int PitchBits   = $clog2(PitchCount);
  localparam int VelBits     = 7;
  localparam int TickInBits  = 32;
  localparam int FoldCntBits = $clog2(TickInBits);

  // defaults for the top level parameters and registers
  localparam int DefTickBits  = 24;
  localparam int LoopLenReset = 3840;
  localparam int VelMin       = 1;

  // register indexes on the config port
  localparam logic RegLoopLen = 1'b0;
  localparam logic RegRecEn   = 1'b1;

  typedef enum logic [1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_CLEAR    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FOLD,
    ST_FIX,
    ST_FINISH
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic clear_all;
    logic fold_step;
    logic fold_fix;
    logic write_entry;
    logic load_out;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rec_en;
    logic len_zero;
    logic fold_last;
    logic is_note_on;
    logic entry_open;
  } dp_stat_t;

endpackage

/* design/lnc_ctrl.sv */
module lnc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          opcode_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  lnc_pkg::dp_stat_t   stat_i,
  output lnc_pkg::ctl_cmd_t   cmd_o
);

  lnc_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  lnc_pkg::op_e    op;

  assign op = lnc_pkg::op_e'(opcode_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lnc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lnc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && stat_i.rec_en) begin
          unique case (op)
            lnc_pkg::OP_NOTE_ON, lnc_pkg::OP_NOTE_OFF: begin
              if (!stat_i.len_zero) begin
                cmd_o.load_item = 1'b1;
                state_d         = lnc_pkg::ST_FOLD;
              end
            end
            lnc_pkg::OP_CLEAR: cmd_o.clear_all = 1'b1;
            default: ;
          endcase
        end
      end
      lnc_pkg::ST_FOLD: begin
        cmd_o.fold_step = 1'b1;
        if (stat_i.fold_last) begin
          state_d = lnc_pkg::ST_FIX;
        end
      end
      lnc_pkg::ST_FIX: begin
        cmd_o.fold_fix = 1'b1;
        state_d        = lnc_pkg::ST_FINISH;
      end
      lnc_pkg::ST_FINISH: begin
        priority if (stat_i.is_note_on) begin
          cmd_o.write_entry = 1'b1;
          state_d           = lnc_pkg::ST_IDLE;
        end else if (!stat_i.entry_open) begin
          state_d = lnc_pkg::ST_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = lnc_pkg::ST_IDLE;
        end else begin
          // output register still holds an unaccepted beat
          state_d = lnc_pkg::ST_FINISH;
        end
      end
      default: state_d = lnc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* design/lnc_dpath.sv */
module lnc_dpath #(
  parameter int TICK_BITS = lnc_pkg::DefTickBits
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic                                   cfg_index_i,
  input  logic [TICK_BITS-1:0]                   cfg_wdata_i,
  input  logic [1:0]                             opcode_i,
  input  logic [lnc_pkg::PitchBits-1:0]          note_pitch_i,
  input  logic [lnc_pkg::VelBits-1:0]            note_velocity_i,
  input  logic signed [lnc_pkg::TickInBits-1:0]  event_tick_i,
  input  lnc_pkg::ctl_cmd_t                      cmd_i,
  output lnc_pkg::dp_stat_t                      stat_o,
  output logic [lnc_pkg::PitchBits-1:0]          done_pitch_o,
  output logic [lnc_pkg::VelBits-1:0]            done_velocity_o,
  output logic [TICK_BITS-1:0]                   done_start_o,
  output logic [TICK_BITS-1:0]                   done_length_o
);

  localparam int WordBits = lnc_pkg::VelBits + TICK_BITS;
  localparam int DurBits  = TICK_BITS + 2;
  localparam logic [TICK_BITS-1:0] LenReset = TICK_BITS'(lnc_pkg::LoopLenReset);
  localparam logic [lnc_pkg::VelBits-1:0] VelFloor = lnc_pkg::VelBits'(lnc_pkg::VelMin);
  localparam logic [DurBits-1:0] DurOne = DurBits'(1);

  // config registers
  logic [TICK_BITS-1:0] loop_len_q;
  logic                 rec_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_len_q <= LenReset;
      rec_en_q   <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == lnc_pkg::RegLoopLen) begin
        loop_len_q <= cfg_wdata_i;
      end else if (cfg_index_i == lnc_pkg::RegRecEn) begin
        rec_en_q <= cfg_wdata_i[0];
      end
    end
  end

  // latched item and fold state
  logic [lnc_pkg::PitchBits-1:0]   pitch_q;
  logic [lnc_pkg::VelBits-1:0]     vel_q;
  logic                            note_on_q;
  logic                            neg_q;
  logic [lnc_pkg::TickInBits-1:0]  mag_q;
  logic [TICK_BITS:0]              rem_q;
  logic [lnc_pkg::FoldCntBits-1:0] cnt_q;
  logic [TICK_BITS-1:0]            fold_q;

  logic [lnc_pkg::TickInBits-1:0]  tick_u;
  logic [TICK_BITS:0]              trial;
  logic [TICK_BITS:0]              trial_sub;

  assign tick_u    = event_tick_i;
  assign trial     = {rem_q[TICK_BITS-1:0], mag_q[lnc_pkg::TickInBits-1]};
  assign trial_sub = (trial >= {1'b0, loop_len_q}) ? (trial - {1'b0, loop_len_q}) : trial;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      pitch_q   <= note_pitch_i;
      vel_q     <= (note_velocity_i < VelFloor) ? VelFloor : note_velocity_i;
      note_on_q <= (lnc_pkg::op_e'(opcode_i) == lnc_pkg::OP_NOTE_ON);
      neg_q     <= tick_u[lnc_pkg::TickInBits-1];
      mag_q     <= tick_u[lnc_pkg::TickInBits-1] ? (-tick_u) : tick_u;
      rem_q     <= '0;
      cnt_q     <= '1;
    end else if (cmd_i.fold_step) begin
      mag_q <= {mag_q[lnc_pkg::TickInBits-2:0], 1'b0};
      rem_q <= trial_sub;
      cnt_q <= cnt_q - 1'b1;
    end
    if (cmd_i.fold_fix) begin
      // truncating remainder of a negative tick flips into [0, len)
      fold_q <= (neg_q && (rem_q != '0)) ? (loop_len_q - rem_q[TICK_BITS-1:0])
                                           : rem_q[TICK_BITS-1:0];
    end
  end

  // open-note memory, velocity above start tick
  logic [WordBits-1:0] note_mem [lnc_pkg::PitchCount];
  logic [WordBits-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_entry) begin
      note_mem[pitch_q] <= {vel_q, fold_q};
    end
    rd_q <= note_mem[pitch_q];
  end

  logic [lnc_pkg::PitchCount-1:0] open_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (cmd_i.clear_all) begin
      open_q <= '0;
    end else if (cmd_i.write_entry) begin
      open_q[pitch_q] <= 1'b1;
    end else if (cmd_i.load_out) begin
      open_q[pitch_q] <= 1'b0;
    end
  end

  // duration with wrap correction and clamp
  logic signed [DurBits-1:0] len_s;
  logic signed [DurBits-1:0] diff;
  logic signed [DurBits-1:0] dur_a;
  logic signed [DurBits-1:0] dur_c;

  always_comb begin
    len_s = $signed({2'b00, loop_len_q});
    diff  = $signed({2'b00, fold_q}) - $signed({2'b00, rd_q[TICK_BITS-1:0]});
    dur_a = (diff[DurBits-1] || (diff == '0)) ? (diff + len_s) : diff;
    priority if (dur_a > len_s) begin
      dur_c = len_s;
    end else if (dur_a[DurBits-1] || (dur_a == '0)) begin
      dur_c = $signed(DurOne);
    end else begin
      dur_c = dur_a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      done_pitch_o    <= pitch_q;
      done_velocity_o <= rd_q[WordBits-1:TICK_BITS];
      done_start_o    <= rd_q[TICK_BITS-1:0];
      done_length_o   <= dur_c[TICK_BITS-1:0];
    end
  end

  assign stat_o.rec_en     = rec_en_q;
  assign stat_o.len_zero   = (loop_len_q == '0);
  assign stat_o.fold_last  = (cnt_q == '0);
  assign stat_o.is_note_on = note_on_q;
  assign stat_o.entry_open = open_q[pitch_q];

endmodule

/* design/loop_note_capture.sv */
// note on / note off: the bit-serial remainder unit takes one dividend bit a cycle,
//   then sign fix and entry update (note on) or result load (note off, open entry)
// a completed note shows on the output in the cycle after the result load
// clear, ignored and disabled beats are taken in idle without leaving it; one item in flight at a time
// async active-low reset: open flags cleared, loop length 3840, recording off
module loop_note_capture #(
  parameter int TICK_BITS = lnc_pkg::DefTickBits
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // config write port
  input  logic                                   cfg_we_i,
  input  logic                                   cfg_index_i,
  input  logic [TICK_BITS-1:0]                   cfg_wdata_i,
  // event beats
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [1:0]                             opcode_i,
  input  logic [lnc_pkg::PitchBits-1:0]          note_pitch_i,
  input  logic [lnc_pkg::VelBits-1:0]            note_velocity_i,
  input  logic signed [lnc_pkg::TickInBits-1:0]  event_tick_i,
  // completed note beats
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [lnc_pkg::PitchBits-1:0]          done_pitch_o,
  output logic [lnc_pkg::VelBits-1:0]            done_velocity_o,
  output logic [TICK_BITS-1:0]                   done_start_o,
  output logic [TICK_BITS-1:0]                   done_length_o
);

  lnc_pkg::ctl_cmd_t cmd;
  lnc_pkg::dp_stat_t stat;

  // sequencer: idle, fold loop, sign fix, entry update / result load
  lnc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // config regs, remainder unit, open-note store and output register
  lnc_dpath #(
    .TICK_BITS (TICK_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .opcode_i        (opcode_i),
    .note_pitch_i    (note_pitch_i),
    .note_velocity_i (note_velocity_i),
    .event_tick_i    (event_tick_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .done_pitch_o    (done_pitch_o),
    .done_velocity_o (done_velocity_o),
    .done_start_o    (done_start_o),
    .done_length_o   (done_length_o)
  );

  // a result is only built from an entry that is still open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> stat.entry_open && !stat.is_note_on)
    else $error("result loaded from a closed entry");

  // no new beat taken while the remainder unit is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fold_step |-> !in_ready_o)
    else $error("input ready during fold");

  // a loaded result is presented on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_o)
    else $error("loaded result not presented");

  // clearing only happens on an accepted beat while recording
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear_all |-> in_valid_i && in_ready_o && stat.rec_en)
    else $error("clear without accepted beat");

endmodule
